// ===== rtl/osis_pkg.sv =====
// Package for the ordered sparse index set: request codes, engine states and
// the request and result records shared by the engine and the top level.
`timescale 1ns / 1ps
package osis_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int RESET_COUNT   = 1024;

    localparam int REQ_W   = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NEXT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_SCAN,
        ST_SPLICE,
        ST_NXT_RD,
        ST_WIPE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [INDEX_W-1:0] item_index;
        logic               from_start;
    } t_req;

    typedef struct packed {
        logic               was_new;
        logic [INDEX_W-1:0] succ_index;
        logic               at_end;
        logic               range_error;
    } t_res;

endpackage

// ===== rtl/osis_engine.sv =====
// Sequencer and link memory of the ordered sparse index set.
// Depends on osis_pkg; one memory read port and one write port are shared
// by the backward scan, the splice, the successor lookup and the clearing pass.
`timescale 1ns / 1ps
module osis_engine import osis_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    localparam int ADDR_W = $clog2(MAX_SLOTS),
    localparam int LINK_W = $clog2(MAX_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LINK_W-1:0] i_slot_count,
    input  logic              i_wipe,
    input  logic              i_start,
    input  t_req              i_req,
    output logic              o_ready,
    output logic              o_done,
    output t_res              o_res,
    input  logic              i_res_ready
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SLOTS - 1);

    logic [LINK_W-1:0] r_mem [MAX_SLOTS];
    logic [LINK_W-1:0] r_rdata;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    t_res              r_res, n_res;
    logic [LINK_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_qa, n_qa;
    logic [ADDR_W-1:0] r_wcnt, n_wcnt;
    logic              r_clr, n_clr;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;

    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] idx_addr;
    logic [LINK_W-1:0] idx_link;
    logic              rdata_zero;

    assign in_range   = 32'(i_req.item_index) < 32'(i_slot_count);
    assign in_addr    = ADDR_W'(32'(i_req.item_index));
    assign idx_addr   = ADDR_W'(32'(r_req.item_index));
    assign idx_link   = LINK_W'(32'(r_req.item_index));
    assign rdata_zero = (r_rdata == '0);

    assign o_ready = (r_state == ST_IDLE);
    assign o_done  = (r_state == ST_DONE);
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WIPE;
            r_wcnt  <= '0;
            r_clr   <= 1'b0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
            r_clr   <= n_clr;
            r_head  <= n_head;
        end
        r_req <= n_req;
        r_res <= n_res;
        r_qa  <= n_qa;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_req.req_type)
                        REQ_INSERT: n_state = in_range ? ST_INS_CHK : ST_DONE;
                        REQ_NEXT: begin
                            if (i_req.from_start || !in_range) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_NXT_RD;
                            end
                        end
                        REQ_CLEAR: n_state = ST_WIPE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_INS_CHK: begin
                if (!rdata_zero || idx_addr == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!rdata_zero) begin
                    n_state = ST_SPLICE;
                end else if (r_qa == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_SPLICE: n_state = ST_DONE;
            ST_NXT_RD: n_state = ST_DONE;
            ST_WIPE: begin
                if (r_wcnt == LAST_ADDR) begin
                    n_state = r_clr ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_wipe) begin
            n_state = ST_WIPE;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = in_addr;
        wr_en   = 1'b0;
        wr_addr = idx_addr;
        wr_data = r_rdata;
        n_req   = r_req;
        n_res   = r_res;
        n_head  = r_head;
        n_qa    = r_qa;
        n_wcnt  = r_wcnt;
        n_clr   = r_clr;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_res = '0;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (!in_range) begin
                                n_res.range_error = 1'b1;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        REQ_NEXT: begin
                            if (i_req.from_start) begin
                                if (r_head == i_slot_count) begin
                                    n_res.at_end = 1'b1;
                                end else begin
                                    n_res.succ_index = INDEX_W'(32'(r_head));
                                end
                            end else if (!in_range) begin
                                n_res.range_error = 1'b1;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            n_wcnt = '0;
                            n_clr  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS_CHK: begin
                if (rdata_zero) begin
                    n_res.was_new = 1'b1;
                    if (idx_addr == '0) begin
                        wr_en   = 1'b1;
                        wr_data = r_head;
                        n_head  = idx_link;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_addr - 1'b1;
                        n_qa    = idx_addr - 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!rdata_zero) begin
                    wr_en = 1'b1;
                end else if (r_qa == '0) begin
                    wr_en   = 1'b1;
                    wr_data = r_head;
                    n_head  = idx_link;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_qa - 1'b1;
                    n_qa    = r_qa - 1'b1;
                end
            end
            ST_SPLICE: begin
                wr_en   = 1'b1;
                wr_addr = r_qa;
                wr_data = idx_link;
            end
            ST_NXT_RD: begin
                if (rdata_zero || r_rdata == i_slot_count) begin
                    n_res.at_end = 1'b1;
                end else begin
                    n_res.succ_index = INDEX_W'(32'(r_rdata));
                end
            end
            ST_WIPE: begin
                wr_en   = 1'b1;
                wr_addr = r_wcnt;
                wr_data = '0;
                n_head  = i_slot_count;
                n_wcnt  = r_wcnt + 1'b1;
            end
            ST_DONE: n_clr = 1'b0;
            default: ;
        endcase
        if (i_wipe) begin
            n_wcnt = '0;
            n_clr  = 1'b0;
        end
    end

endmodule

// ===== rtl/ordered_sparse_index_set.sv =====
// Top level of the ordered sparse index set: stream ports, configuration
// port and output register. Depends on osis_pkg and osis_engine.
//
// Requests enter on the s_axis channel, one item per handshake; each gives
// one result item on the m_axis channel unless a write of slot_count cuts
// it off. An insert adds an absent index to an ascending linked list,
// scanning backward one link memory read per cycle. A next request returns
// the successor of an index, or the first entry, and a clear request
// empties the set. An insert of an absent index scans backward over the
// absent slots until it stops at a present index or reaches the head. The
// single port pair of the link memory is shared by all steps; items go one
// at a time.
// After reset, and after every write of slot_count, a clearing pass zeroes
// all MAX_SLOTS slots of the link memory; no item is accepted meanwhile.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and worked on, and its result waits inside until the
// register is free.
`timescale 1ns / 1ps
module ordered_sparse_index_set import osis_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // item_index[9:0], zero [15:10]
    input  logic [2:0]  s_axis_tuser,   // req_type[1:0], from_start[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // succ_index[9:0], zero [15:10]
    output logic [2:0]  m_axis_tuser,   // was_new[0], at_end[1], range_error[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LINK_W = $clog2(MAX_SLOTS + 1);
    localparam int RESET_LIMIT = (RESET_COUNT > MAX_SLOTS) ? MAX_SLOTS : RESET_COUNT;

    logic [LINK_W-1:0] r_slot_count;
    logic              r_out_valid;
    t_res              r_out;

    logic              cfg_wr;
    logic [COUNT_W-1:0] wr_val;
    logic [LINK_W-1:0] limited;
    logic              eng_ready;
    logic              eng_done;
    logic              res_ready;
    t_req              req;
    t_res              eng_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign wr_val = pwdata[COUNT_W-1:0];

    always_comb begin
        if (wr_val == '0) begin
            limited = LINK_W'(1);
        end else if (32'(wr_val) > 32'(MAX_SLOTS)) begin
            limited = LINK_W'(MAX_SLOTS);
        end else begin
            limited = LINK_W'(32'(wr_val));
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? 32'(r_slot_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= LINK_W'(RESET_LIMIT);
        end else if (cfg_wr) begin
            r_slot_count <= limited;
        end
    end

    assign req.req_type   = s_axis_tuser[1:0];
    assign req.from_start = s_axis_tuser[2];
    assign req.item_index = s_axis_tdata[INDEX_W-1:0];

    assign res_ready = !r_out_valid || m_axis_tready;

    osis_engine #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_count (r_slot_count),
        .i_wipe       (cfg_wr),
        .i_start      (s_axis_tvalid),
        .i_req        (req),
        .o_ready      (eng_ready),
        .o_done       (eng_done),
        .o_res        (eng_res),
        .i_res_ready  (res_ready)
    );

    assign s_axis_tready = eng_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (eng_done && res_ready) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.succ_index};
    assign m_axis_tuser  = {r_out.range_error, r_out.at_end, r_out.was_new};

endmodule
